// ----- rtl/core/gbalu_pkg.sv -----
package gbalu_pkg;

   localparam logic [3:0] CMD_INC   = 4'd0;
   localparam logic [3:0] CMD_DEC   = 4'd1;
   localparam logic [3:0] CMD_ADD   = 4'd2;
   localparam logic [3:0] CMD_ADC   = 4'd3;
   localparam logic [3:0] CMD_SUB   = 4'd4;
   localparam logic [3:0] CMD_SBC   = 4'd5;
   localparam logic [3:0] CMD_ADDHL = 4'd6;
   localparam logic [3:0] CMD_ADDSP = 4'd7;
   localparam logic [3:0] CMD_RL    = 4'd8;
   localparam logic [3:0] CMD_RLC   = 4'd9;
   localparam logic [3:0] CMD_RR    = 4'd10;
   localparam logic [3:0] CMD_RRC   = 4'd11;
   localparam logic [3:0] CMD_SLA   = 4'd12;
   localparam logic [3:0] CMD_SRA   = 4'd13;
   localparam logic [3:0] CMD_SRL   = 4'd14;
   localparam logic [3:0] CMD_BIT   = 4'd15;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [3:0]  command;
      logic [7:0]  accumulator;
      logic [7:0]  operand;
      logic [15:0] base_word;
      logic [15:0] wide_operand;
      logic [2:0]  bit_index;
      logic        rotate_on_a;
   } op_type;

   typedef struct packed {
      logic [7:0]  byte_result;
      logic [15:0] word_result;
      flags_type   flags;
   } res_type;

endpackage

// ----- rtl/core/cpu_alu_with_flag_register_top.sv -----
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | command, operands, bit index, rotate form
// rsp     | out       | rsp_valid/rsp_ready  | byte and word result, Z N H C flags
//
// One item per cycle sustained while rsp is not stalled; an accepted item passes through
// the input register, the ALU logic and the result register, which drives rsp_valid.
// The flag register updates as an item moves into the result register, so the next
// item sees the flags left by the one before it.
// Synchronous reset clears the flags and both valid bits.
// A stalled rsp holds the result; the input register still fills, then req_ready drops.
module cpu_alu_with_flag_register_top import gbalu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_command,
   input  logic [7:0]  req_accumulator,
   input  logic [7:0]  req_operand,
   input  logic [15:0] req_base_word,
   input  logic [15:0] req_wide_operand,
   input  logic [2:0]  req_bit_index,
   input  logic        req_rotate_on_a,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_result,
   output logic [15:0] rsp_word_result,
   output logic        rsp_zero_flag,
   output logic        rsp_subtract_flag,
   output logic        rsp_half_carry_flag,
   output logic        rsp_carry_flag
);

   logic      op_valid_ff;
   op_type    op_ff;
   logic      res_valid_ff;
   res_type   res_ff;
   flags_type flags_ff;
   flags_type flags_in;
   res_type   res_in;
   logic      advance;

   assign advance   = op_valid_ff && (!res_valid_ff || rsp_ready);
   assign req_ready = !op_valid_ff || advance;

   gbalu_core u_core (
      .op        (op_ff),
      .flags_cur (flags_ff),
      .res       (res_in)
   );

   assign flags_in = advance ? res_in.flags : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_ready) begin
            op_valid_ff <= req_valid;
         end
         if (advance) begin
            res_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            res_valid_ff <= 1'b0;
         end
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         op_ff <= '{command: req_command, accumulator: req_accumulator,
                    operand: req_operand, base_word: req_base_word,
                    wide_operand: req_wide_operand, bit_index: req_bit_index,
                    rotate_on_a: req_rotate_on_a};
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid           = res_valid_ff;
   assign rsp_byte_result     = res_ff.byte_result;
   assign rsp_word_result     = res_ff.word_result;
   assign rsp_zero_flag       = res_ff.flags.z;
   assign rsp_subtract_flag   = res_ff.flags.n;
   assign rsp_half_carry_flag = res_ff.flags.h;
   assign rsp_carry_flag      = res_ff.flags.c;

endmodule

// ----- rtl/core/gbalu_core.sv -----
module gbalu_core import gbalu_pkg::*; (
   input  op_type    op,
   input  flags_type flags_cur,
   output res_type   res
);

   logic [7:0]  r;
   logic [7:0]  a;
   logic        cin;
   logic [8:0]  sum9;
   logic [4:0]  sum5;
   logic [8:0]  dif9;
   logic [4:0]  dif5;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic [15:0] ext;
   logic [8:0]  sp_lo8;
   logic [4:0]  sp_lo4;
   logic [7:0]  b;

   always_comb begin
      r   = op.operand;
      a   = op.accumulator;
      cin = ((op.command == CMD_ADC) || (op.command == CMD_SBC)) ? flags_cur.c : 1'b0;

      sum9  = {1'b0, a} + {1'b0, r} + {8'd0, cin};
      sum5  = {1'b0, a[3:0]} + {1'b0, r[3:0]} + {4'd0, cin};
      // borrow shows up as the top bit of the extended difference
      dif9  = {1'b0, a} - {1'b0, r} - {8'd0, cin};
      dif5  = {1'b0, a[3:0]} - {1'b0, r[3:0]} - {4'd0, cin};
      sum17 = {1'b0, op.base_word} + {1'b0, op.wide_operand};
      sum13 = {1'b0, op.base_word[11:0]} + {1'b0, op.wide_operand[11:0]};
      ext    = {{8{op.wide_operand[7]}}, op.wide_operand[7:0]};
      sp_lo8 = {1'b0, op.base_word[7:0]} + {1'b0, op.wide_operand[7:0]};
      sp_lo4 = {1'b0, op.base_word[3:0]} + {1'b0, op.wide_operand[3:0]};

      res.byte_result = 8'd0;
      res.word_result = 16'd0;
      res.flags       = flags_cur;
      b               = 8'd0;

      case (op.command)
         CMD_INC: begin
            b = r + 8'd1;
            res.flags = '{z: (b == 8'd0), n: 1'b0, h: (b[3:0] == 4'h0), c: flags_cur.c};
         end
         CMD_DEC: begin
            b = r - 8'd1;
            res.flags = '{z: (b == 8'd0), n: 1'b1, h: (b[3:0] == 4'hF), c: flags_cur.c};
         end
         CMD_ADD, CMD_ADC: begin
            b = sum9[7:0];
            res.flags = '{z: (b == 8'd0), n: 1'b0, h: sum5[4], c: sum9[8]};
         end
         CMD_SUB, CMD_SBC: begin
            b = dif9[7:0];
            res.flags = '{z: (b == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
         end
         CMD_ADDHL: begin
            res.word_result = sum17[15:0];
            res.flags = '{z: flags_cur.z, n: 1'b0, h: sum13[12], c: sum17[16]};
         end
         CMD_ADDSP: begin
            res.word_result = op.base_word + ext;
            res.flags = '{z: 1'b0, n: 1'b0, h: sp_lo4[4], c: sp_lo8[8]};
         end
         CMD_RL, CMD_RLC, CMD_RR, CMD_RRC: begin
            case (op.command)
               CMD_RL:  b = {r[6:0], flags_cur.c};
               CMD_RLC: b = {r[6:0], r[7]};
               CMD_RR:  b = {flags_cur.c, r[7:1]};
               default: b = {r[0], r[7:1]};
            endcase
            res.flags = '{z: (!op.rotate_on_a && (b == 8'd0)), n: 1'b0, h: 1'b0,
                          c: ((op.command == CMD_RL) || (op.command == CMD_RLC)) ? r[7] : r[0]};
         end
         CMD_SLA: begin
            b = {r[6:0], 1'b0};
            res.flags = '{z: (b == 8'd0), n: 1'b0, h: 1'b0, c: r[7]};
         end
         CMD_SRA: begin
            b = {r[7], r[7:1]};
            res.flags = '{z: (b == 8'd0), n: 1'b0, h: 1'b0, c: r[0]};
         end
         CMD_SRL: begin
            b = {1'b0, r[7:1]};
            res.flags = '{z: (b == 8'd0), n: 1'b0, h: 1'b0, c: r[0]};
         end
         default: begin
            res.flags = '{z: !r[op.bit_index], n: 1'b0, h: 1'b1, c: flags_cur.c};
         end
      endcase

      res.byte_result = b;
   end

endmodule

// ----- rtl/core/gbalu_checker.sv -----
module gbalu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_byte_result,
   input logic [15:0] rsp_word_result,
   input logic        rsp_zero_flag,
   input logic        rsp_subtract_flag
);

   // a waiting item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_result)
                                  && $stable(rsp_word_result))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // only the 16-bit adds fill the word result, and they leave the byte at zero
   a_word_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word_result != 16'd0) |-> rsp_byte_result == 8'd0)
      else $error("byte and word results both set");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_result != 8'd0) |-> !rsp_zero_flag)
      else $error("Z set on nonzero byte result");

   a_sub_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_subtract_flag |-> rsp_word_result == 16'd0)
      else $error("N set on a 16-bit add");

endmodule

bind cpu_alu_with_flag_register_top gbalu_checker u_gbalu_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_byte_result   (rsp_byte_result),
   .rsp_word_result   (rsp_word_result),
   .rsp_zero_flag     (rsp_zero_flag),
   .rsp_subtract_flag (rsp_subtract_flag)
);
